// ===== hw/rtl/srd_pkg.sv =====
// package for the snell refraction direction unit
// payload structs and fixed-point constants; no dependencies
package srd_pkg;

  localparam int FracBits = 14;
  localparam int EtaFrac  = 12;

  typedef struct packed {
    logic signed [15:0] in_dir_x;
    logic signed [15:0] in_dir_y;
    logic signed [15:0] in_dir_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic        [15:0] index_ratio;
  } srd_in_t;

  typedef struct packed {
    logic signed [15:0] out_dir_x;
    logic signed [15:0] out_dir_y;
    logic signed [15:0] out_dir_z;
    logic               total_reflection;
  } srd_out_t;

endpackage

// ===== hw/rtl/srd_sqrt.sv =====
// pipelined integer square root, rounded to nearest, one result bit per stage
// does not use srd_pkg; stalls with the parent pipeline
module srd_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [27:0] radicand,
  output logic [14:0] root
);

  // 14 result bits, one per stage; rounding in a final stage
  localparam int Steps = 14;

  logic [27:0] rem_q  [Steps+1];
  logic [13:0] res_q  [Steps+1];
  logic [27:0] rad_q  [Steps+1];

  assign rem_q[0] = '0;
  assign res_q[0] = '0;
  assign rad_q[0] = radicand;

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [27:0] rem_r, rad_r;
    logic [13:0] res_r;
    logic [29:0] trial;
    logic [29:0] cur;
    always_comb begin
      // bring down next two bits of the radicand
      cur   = {rem_q[s], rad_q[s][27:26]};
      trial = {14'd0, res_q[s], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rad_r <= {rad_q[s][25:0], 2'b00};
        if (cur >= trial) begin
          rem_r <= 28'(cur - trial);
          res_r <= {res_q[s][12:0], 1'b1};
        end else begin
          rem_r <= cur[27:0];
          res_r <= {res_q[s][12:0], 1'b0};
        end
      end
    end
    assign rem_q[s+1] = rem_r;
    assign res_q[s+1] = res_r;
    assign rad_q[s+1] = rad_r;
  end

  // remainder above root means round up
  always_ff @(posedge clk) begin
    if (en) begin
      root <= (rem_q[Steps] > {14'd0, res_q[Steps]}) ?
              15'({1'b0, res_q[Steps]} + 15'd1) : {1'b0, res_q[Steps]};
    end
  end

endmodule

// ===== hw/rtl/snell_refraction_direction_unit.sv =====
// snell refraction direction unit, top level
// depends on srd_pkg and srd_sqrt
// 23 register stages; throughput one item per cycle while the output is not stalled
// the pipeline advances whenever the output register is empty or being taken,
// so in_ready is low only while a finished result waits downstream or during reset
// reset clears all valid bits; payload registers are not reset
module snell_refraction_direction_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  srd_pkg::srd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output srd_pkg::srd_out_t out_data
);

  localparam int Depth = 23;

  logic en;
  logic [Depth-1:0] vld;

  assign en       = !out_valid || out_ready;
  assign in_ready = en && !rst;
  assign out_valid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end

  // stage 1: products of the dot
  logic signed [15:0] wx1, wy1, wz1, nx1, ny1, nz1;
  logic        [15:0] eta1;
  logic signed [31:0] px1, py1, pz1;
  always_ff @(posedge clk) begin
    if (en) begin
      wx1 <= in_data.in_dir_x;  wy1 <= in_data.in_dir_y;  wz1 <= in_data.in_dir_z;
      nx1 <= in_data.normal_x;  ny1 <= in_data.normal_y;  nz1 <= in_data.normal_z;
      eta1 <= in_data.index_ratio;
      px1 <= in_data.in_dir_x * in_data.normal_x;
      py1 <= in_data.in_dir_y * in_data.normal_y;
      pz1 <= in_data.in_dir_z * in_data.normal_z;
    end
  end

  // stage 2: sum and round cos to Q14; eta squared
  logic signed [33:0] dot_w;
  logic signed [19:0] c2;
  logic signed [15:0] wx2, wy2, wz2, nx2, ny2, nz2;
  logic        [15:0] eta2;
  logic        [31:0] eta_sq2;
  always_comb dot_w = 34'(px1) + 34'(py1) + 34'(pz1) + 34'sd8192;
  always_ff @(posedge clk) begin
    if (en) begin
      c2 <= dot_w[33:14];
      wx2 <= wx1; wy2 <= wy1; wz2 <= wz1; nx2 <= nx1; ny2 <= ny1; nz2 <= nz1;
      eta2 <= eta1;
      eta_sq2 <= eta1 * eta1;
    end
  end

  // stage 3: cos squared
  logic signed [19:0] c3;
  logic        [39:0] csq3;
  logic signed [15:0] wx3, wy3, wz3, nx3, ny3, nz3;
  logic        [15:0] eta3;
  logic        [31:0] eta_sq3;
  always_ff @(posedge clk) begin
    if (en) begin
      c3 <= c2;
      csq3 <= 40'(c2 * c2);
      wx3 <= wx2; wy3 <= wy2; wz3 <= wz2; nx3 <= nx2; ny3 <= ny2; nz3 <= nz2;
      eta3 <= eta2; eta_sq3 <= eta_sq2;
    end
  end

  // stage 4: sin2i, clamped and rounded to Q14 (at most 2^14)
  logic [40:0] s2w;
  logic [14:0] sin2i4;
  logic signed [19:0] c4;
  logic signed [15:0] wx4, wy4, wz4, nx4, ny4, nz4;
  logic        [15:0] eta4;
  logic        [31:0] eta_sq4;
  always_comb s2w = {12'd0, 29'h10000000} - {1'b0, csq3};
  always_ff @(posedge clk) begin
    if (en) begin
      if (s2w[40]) sin2i4 <= '0;
      else sin2i4 <= 15'((s2w[28:0] + 29'd8192) >> 14);
      c4 <= c3;
      wx4 <= wx3; wy4 <= wy3; wz4 <= wz3; nx4 <= nx3; ny4 <= ny3; nz4 <= nz3;
      eta4 <= eta3; eta_sq4 <= eta_sq3;
    end
  end

  // stage 5: sin2t in Q38
  logic [46:0] st5;
  logic signed [19:0] c5;
  logic signed [15:0] wx5, wy5, wz5, nx5, ny5, nz5;
  logic        [15:0] eta5;
  always_ff @(posedge clk) begin
    if (en) begin
      st5 <= eta_sq4 * sin2i4;
      c5 <= c4;
      wx5 <= wx4; wy5 <= wy4; wz5 <= wz4; nx5 <= nx4; ny5 <= ny4; nz5 <= nz4;
      eta5 <= eta4;
    end
  end

  // stage 6: reflection test and 1 - sin2t rounded to Q28
  logic [38:0] dw;
  logic        tir6;
  logic [27:0] rad6;
  logic signed [19:0] c6;
  logic signed [15:0] wx6, wy6, wz6, nx6, ny6, nz6;
  logic        [15:0] eta6;
  always_comb dw = 39'(39'h4000000000 - 39'(st5)) + 39'd512;
  always_ff @(posedge clk) begin
    if (en) begin
      tir6 <= (st5 >= 47'h4000000000);
      // a radicand of exactly 2^28 rounds to the same root as 2^28 - 1
      rad6 <= dw[38] ? '1 : dw[37:10];
      c6 <= c5;
      wx6 <= wx5; wy6 <= wy5; wz6 <= wz5; nx6 <= nx5; ny6 <= ny5; nz6 <= nz5;
      eta6 <= eta5;
    end
  end

  // stages 7..21: square root; side data rides a delay line
  localparam int SqD = 15;
  logic [14:0] cost;
  srd_sqrt u_sqrt (.clk(clk), .en(en), .radicand(rad6), .root(cost));

  logic        tir_d [SqD];
  logic signed [19:0] c_d [SqD];
  logic signed [15:0] wx_d [SqD], wy_d [SqD], wz_d [SqD];
  logic signed [15:0] nx_d [SqD], ny_d [SqD], nz_d [SqD];
  logic        [15:0] eta_d [SqD];
  always_ff @(posedge clk) begin
    if (en) begin
      tir_d[0] <= tir6; c_d[0] <= c6; eta_d[0] <= eta6;
      wx_d[0] <= wx6; wy_d[0] <= wy6; wz_d[0] <= wz6;
      nx_d[0] <= nx6; ny_d[0] <= ny6; nz_d[0] <= nz6;
      for (int i = 1; i < SqD; i++) begin
        tir_d[i] <= tir_d[i-1]; c_d[i] <= c_d[i-1]; eta_d[i] <= eta_d[i-1];
        wx_d[i] <= wx_d[i-1]; wy_d[i] <= wy_d[i-1]; wz_d[i] <= wz_d[i-1];
        nx_d[i] <= nx_d[i-1]; ny_d[i] <= ny_d[i-1]; nz_d[i] <= nz_d[i-1];
      end
    end
  end

  // stage 22: k = eta*c - cost<<12 (Q26) and -eta*wi
  localparam int L = SqD - 1;
  logic signed [37:0] k22;
  logic signed [33:0] ax22, ay22, az22;
  logic signed [15:0] nx22, ny22, nz22;
  logic               tir22;
  logic signed [16:0] eta_s;
  always_comb eta_s = signed'({1'b0, eta_d[L]});
  always_ff @(posedge clk) begin
    if (en) begin
      k22 <= 38'(eta_s * c_d[L]) - 38'(signed'({1'b0, cost, 12'd0}));
      ax22 <= -34'(eta_s * wx_d[L]);
      ay22 <= -34'(eta_s * wy_d[L]);
      az22 <= -34'(eta_s * wz_d[L]);
      nx22 <= nx_d[L]; ny22 <= ny_d[L]; nz22 <= nz_d[L];
      tir22 <= tir_d[L];
    end
  end

  // stage 23: k*n (38x16), add, round, saturate
  function automatic logic signed [15:0] fin(input logic signed [33:0] a,
                                             input logic signed [37:0] k,
                                             input logic signed [15:0] n);
    logic signed [55:0] s;
    logic signed [29:0] r;
    s = (56'(a) <<< 14) + 56'(k * n) + 56'sd33554432;
    r = s[55:26];
    if (r > 30'sd32767) fin = 16'sh7fff;
    else if (r < -30'sd32768) fin = 16'sh8000;
    else fin = r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.total_reflection <= tir22;
      if (tir22) begin
        out_data.out_dir_x <= '0; out_data.out_dir_y <= '0; out_data.out_dir_z <= '0;
      end else begin
        out_data.out_dir_x <= fin(ax22, k22, nx22);
        out_data.out_dir_y <= fin(ay22, k22, ny22);
        out_data.out_dir_z <= fin(az22, k22, nz22);
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("ready does not follow output stage");
  a_tir_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.total_reflection |->
      out_data.out_dir_x == 16'sd0 && out_data.out_dir_y == 16'sd0 &&
      out_data.out_dir_z == 16'sd0)
    else $error("reflection with nonzero vector");

endmodule
